/* rtl/pwm_motif_window_scan_assert.svh */
// Assertion macros shared by the scanner's RTL files.
// Both expect the enclosing module to have i_clk and i_rst_n.
`ifndef PWM_MOTIF_WINDOW_SCAN_ASSERT_SVH
`define PWM_MOTIF_WINDOW_SCAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pmws_pkg.sv */
package pmws_pkg;

    localparam int NUM_ROWS    = 4;
    localparam int ROW_W       = 2;
    localparam int OP_W        = 1;
    localparam int COLUMN_W    = 5;
    localparam int IN_WEIGHT_W = 16;
    localparam int CODE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int MIN_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [LEN_W-1:0] SEEN_MAX  = '1;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd8;
    localparam logic signed [MIN_W-1:0] MIN_RESET = '0;
    localparam logic [NUM_ROWS-1:0][CODE_W-1:0] CODE_RESET = {8'd84, 8'd71, 8'd67, 8'd65};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 1'b0,
        OP_BASE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTIF_LENGTH = 3'd0,
        CFG_THRESHOLD    = 3'd1,
        CFG_CODE_ROW0    = 3'd2,
        CFG_CODE_ROW1    = 3'd3,
        CFG_CODE_ROW2    = 3'd4,
        CFG_CODE_ROW3    = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [LEN_W-1:0]                  motif_length;
        logic signed [MIN_W-1:0]           threshold;
        logic [NUM_ROWS-1:0][CODE_W-1:0]   code_row;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]               op;
        logic [COLUMN_W-1:0]           column;
        logic [ROW_W-1:0]              row;
        logic signed [IN_WEIGHT_W-1:0] weight_value;
        logic [CODE_W-1:0]             base;
        logic                          last;
    } t_in_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_load;
        logic accept_base;
        logic start_scan;
        logic scan_step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic scan_last;
        logic last_pending;
        logic out_full;
    } t_dp_sts;

endpackage

/* rtl/pmws_in_if.sv */
interface pmws_in_if import pmws_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               op;
    logic [COLUMN_W-1:0]           column;
    logic [ROW_W-1:0]              row;
    logic signed [IN_WEIGHT_W-1:0] weight_value;
    logic [CODE_W-1:0]             base;
    logic                          last;

    modport source (output valid, op, column, row, weight_value, base, last, input ready);
    modport sink (input valid, op, column, row, weight_value, base, last, output ready);
endinterface

/* rtl/pmws_out_if.sv */
interface pmws_out_if import pmws_pkg::*; ();
    logic valid;
    logic ready;
    logic matched;
    logic unknown_seen;

    modport source (output valid, matched, unknown_seen, input ready);
    modport sink (input valid, matched, unknown_seen, output ready);
endinterface

/* rtl/pmws_cfg_if.sv */
interface pmws_cfg_if import pmws_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/pwm_motif_window_scan.sv */
// Position weight matrix motif scanner. Weights (signed Q8.8, four rows per column) are loaded
// with op 0 transfers; a column outside the matrix is ignored, and each weight that a window
// uses must have been written beforehand. Sequence bytes arrive with op 1 transfers and are
// mapped to a matrix row through the four code registers, the lowest row winning on equal
// codes; a byte matching no code adds nothing to any window and marks the sequence as holding
// an unknown byte. Every full window of motif_length bases, clamped to 1 to MAX_COLUMNS, is
// scored as the exact sum of its weights and compared with the score threshold, and on the
// byte flagged last a single result transfer reports whether any window matched and whether
// an unknown byte was seen, both zero for a sequence shorter than the window, after which the
// scan state starts afresh. A sequence byte whose window is full is scanned one column per
// cycle, because the weight memory has a single read port; a final byte waits longer only
// while an earlier result is still held in the output register. Configuration is taken in
// any cycle, and no clearing pass is needed after reset.
module pwm_motif_window_scan import pmws_pkg::*; #(
    parameter int MAX_COLUMNS = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pmws_in_if.sink           i_in,
    pmws_out_if.source        o_out,
    pmws_cfg_if.sink          i_cfg
);

    t_cfg     r_cfg;
    t_in_item in_item;
    t_dp_cmd  dp_cmd;
    t_dp_sts  dp_sts;
    logic     in_ready;

    // The register file is always ready; a transfer to an unused index is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motif_length <= LEN_RESET;
            r_cfg.threshold    <= MIN_RESET;
            r_cfg.code_row     <= CODE_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.reg_index))
                CFG_MOTIF_LENGTH: r_cfg.motif_length <= i_cfg.wr_data[LEN_W-1:0];
                CFG_THRESHOLD:    r_cfg.threshold    <= i_cfg.wr_data[MIN_W-1:0];
                CFG_CODE_ROW0:    r_cfg.code_row[0]  <= i_cfg.wr_data[CODE_W-1:0];
                CFG_CODE_ROW1:    r_cfg.code_row[1]  <= i_cfg.wr_data[CODE_W-1:0];
                CFG_CODE_ROW2:    r_cfg.code_row[2]  <= i_cfg.wr_data[CODE_W-1:0];
                CFG_CODE_ROW3:    r_cfg.code_row[3]  <= i_cfg.wr_data[CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.op           = i_in.op;
    assign in_item.column       = i_in.column;
    assign in_item.row          = i_in.row;
    assign in_item.weight_value = i_in.weight_value;
    assign in_item.base         = i_in.base;
    assign in_item.last         = i_in.last;
    assign i_in.ready           = in_ready;

    // The controller sequences each byte; the datapath holds the window, weights and score.
    pmws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    pmws_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_item             (in_item),
        .i_cmd              (dp_cmd),
        .o_sts              (dp_sts),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_out_matched      (o_out.matched),
        .o_out_unknown_seen (o_out.unknown_seen)
    );

endmodule

/* rtl/pmws_ram.sv */
module pmws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/pmws_ctrl.sv */
`include "pwm_motif_window_scan_assert.svh"

module pmws_ctrl import pmws_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_in_op,
    output logic            o_in_ready,
    input  t_dp_sts         i_sts,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_op == OP_BASE) begin
                        o_cmd.accept_base = 1'b1;
                        n_state           = S_EVAL;
                    end else begin
                        o_cmd.accept_load = 1'b1;
                    end
                end
            end
            S_EVAL: begin
                o_cmd.start_scan = 1'b1;
                n_state          = i_sts.full ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // A final byte waits here until the result register is free.
                if (!i_sts.last_pending || !i_sts.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PMWS_ASSERT_NEXT(a_base_goes_to_eval, accept && i_in_op == OP_BASE, r_state == S_EVAL, "sequence byte transfer did not start an evaluation")
    `PMWS_ASSERT_SAME(a_scan_needs_full_window, r_state == S_SCAN, i_sts.full, "window scan running without a full window")

endmodule

/* rtl/pmws_dp.sv */
`include "pwm_motif_window_scan_assert.svh"

module pmws_dp import pmws_pkg::*; #(
    parameter int MAX_COLUMNS = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_in_item i_item,
    input  t_dp_cmd  i_cmd,
    output t_dp_sts  o_sts,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output logic     o_out_matched,
    output logic     o_out_unknown_seen
);

    localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int SUM_W     = WEIGHT_BITS + COL_W + 1;
    localparam int CMP_W     = (SUM_W > MIN_W) ? SUM_W : MIN_W;
    localparam int WIDE_W    = 9;
    localparam logic [WIDE_W-1:0] MAX_COLS_V = WIDE_W'(MAX_COLUMNS);

    // Window of recent bases, newest at index 0.
    logic [ROW_W-1:0]       r_win_row [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] r_win_known;
    logic [LEN_W-1:0]       r_seen;
    logic                   r_match;
    logic                   r_unk;
    logic                   r_full;
    logic                   r_last;
    logic [COL_W-1:0]       r_len_m1;
    logic [COL_W-1:0]       r_col;
    logic                   r_add_en;
    logic                   r_add_known;
    logic signed [SUM_W-1:0] r_acc;
    logic                   r_out_valid;
    logic                   r_out_matched;
    logic                   r_out_unknown;

    logic [LEN_W-1:0]       eff_len;
    logic [WIDE_W-1:0]      len_m1_wide;
    logic [ROW_W-1:0]       map_row;
    logic                   map_known;
    logic [LEN_W-1:0]       seen_next;
    logic [WIDE_W-1:0]      col_wide;
    logic [31:0]            wt_ext;
    logic                   wr_en;
    logic [COL_W-1:0]       win_idx;
    logic [ADDR_W-1:0]      rd_addr;
    logic [WEIGHT_BITS-1:0] rd_data;
    logic signed [CMP_W-1:0] acc_x;
    logic signed [CMP_W-1:0] min_x;
    logic                   match_now;
    logic                   out_full;

    // Window length, clamped to the range the matrix can hold.
    always_comb begin
        priority if (i_cfg.motif_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (WIDE_W'(i_cfg.motif_length) > MAX_COLS_V) begin
            eff_len = LEN_W'(MAX_COLUMNS);
        end else begin
            eff_len = i_cfg.motif_length;
        end
    end

    assign len_m1_wide = WIDE_W'(eff_len) - WIDE_W'(1);

    // Lowest row wins where two codes are equal.
    always_comb begin
        map_known = 1'b1;
        priority if (i_item.base == i_cfg.code_row[0]) begin
            map_row = ROW_W'(0);
        end else if (i_item.base == i_cfg.code_row[1]) begin
            map_row = ROW_W'(1);
        end else if (i_item.base == i_cfg.code_row[2]) begin
            map_row = ROW_W'(2);
        end else if (i_item.base == i_cfg.code_row[3]) begin
            map_row = ROW_W'(3);
        end else begin
            map_row   = '0;
            map_known = 1'b0;
        end
    end

    assign seen_next = (r_seen == SEEN_MAX) ? r_seen : r_seen + LEN_W'(1);

    assign col_wide = WIDE_W'(i_item.column);
    assign wt_ext   = 32'(i_item.weight_value);
    assign wr_en    = i_cmd.accept_load && (col_wide < MAX_COLS_V);

    // Column i of the matrix pairs with the base len-1-i places back.
    assign win_idx = r_len_m1 - r_col;
    assign rd_addr = {r_col, r_win_row[win_idx]};

    pmws_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_weights (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr ({col_wide[COL_W-1:0], i_item.row}),
        .i_wr_data (wt_ext[WEIGHT_BITS-1:0]),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign acc_x     = CMP_W'(r_acc);
    assign min_x     = CMP_W'(i_cfg.threshold);
    assign match_now = r_match | (r_full & (acc_x >= min_x));
    assign out_full  = r_out_valid & ~i_out_ready;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_base) begin
            for (int k = MAX_COLUMNS - 1; k > 0; k--) begin
                r_win_row[k] <= r_win_row[k-1];
            end
            r_win_row[0] <= map_row;
            r_len_m1     <= len_m1_wide[COL_W-1:0];
        end
        if (i_cmd.start_scan) begin
            r_col <= '0;
            r_acc <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_col <= r_col + COL_W'(1);
            end
            if (r_add_en && r_add_known) begin
                r_acc <= r_acc + SUM_W'(signed'(rd_data));
            end
        end
        r_add_known <= r_win_known[win_idx];
        if (i_cmd.finish && r_last) begin
            r_out_matched <= r_full & match_now;
            r_out_unknown <= r_full & r_unk;
        end
    end

    // Scan state and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_known <= '0;
            r_seen      <= '0;
            r_match     <= 1'b0;
            r_unk       <= 1'b0;
            r_full      <= 1'b0;
            r_last      <= 1'b0;
            r_add_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_add_en <= i_cmd.scan_step;
            if (i_cmd.accept_base) begin
                for (int k = MAX_COLUMNS - 1; k > 0; k--) begin
                    r_win_known[k] <= r_win_known[k-1];
                end
                r_win_known[0] <= map_known;
                r_seen         <= seen_next;
                r_unk          <= r_unk | ~map_known;
                r_full         <= (seen_next >= eff_len);
                r_last         <= i_item.last;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_win_known <= '0;
                    r_seen      <= '0;
                    r_match     <= 1'b0;
                    r_unk       <= 1'b0;
                end else begin
                    r_match <= match_now;
                end
            end
            if (i_cmd.finish && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.full         = r_full;
    assign o_sts.scan_last    = (r_col == r_len_m1);
    assign o_sts.last_pending = r_last;
    assign o_sts.out_full     = out_full;

    assign o_out_valid        = r_out_valid;
    assign o_out_matched      = r_out_matched;
    assign o_out_unknown_seen = r_out_unknown;

    `PMWS_ASSERT_SAME(a_no_result_overwrite, i_cmd.finish && r_last, !out_full, "result register loaded while still holding an untaken result")
    `PMWS_ASSERT_NEXT(a_scan_cleared, i_cmd.finish && r_last, r_seen == '0 && !r_match && !r_unk && r_win_known == '0, "scan state not cleared after the final byte")
    `PMWS_ASSERT_NEXT(a_seen_saturates, i_cmd.accept_base && r_seen == SEEN_MAX, r_seen == SEEN_MAX, "base count wrapped instead of saturating")

endmodule

/* verif/pmws_scan_checker.sv */
`timescale 1ns / 100ps

module pmws_scan_checker import pmws_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pmws_in_if   i_in_mon,
    pmws_out_if  i_out_mon,
    pmws_cfg_if  i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int         COLUMNS  = 32;
    localparam logic [2:0] ROW_NONE = 3'd4;

    typedef struct packed {
        logic matched;
        logic unknown_seen;
    } t_verdict;

    logic [LEN_W-1:0]                len_reg;
    logic signed [MIN_W-1:0]         thresh_reg;
    logic [NUM_ROWS-1:0][CODE_W-1:0] code_reg;

    logic signed [IN_WEIGHT_W-1:0] weights [COLUMNS*NUM_ROWS];
    logic [2:0]                    history [COLUMNS];
    logic [LEN_W-1:0]              seen_count;
    logic                          hit_flag;
    logic                          odd_flag;

    t_verdict expected_verdicts [$];

    function automatic int window_span(input logic [LEN_W-1:0] l);
        if (l == 0) return 1;
        if (l > COLUMNS) return COLUMNS;
        return int'(l);
    endfunction

    task automatic restart_scan();
        for (int i = 0; i < COLUMNS; i++) history[i] = ROW_NONE;
        seen_count = '0;
        hit_flag   = 1'b0;
        odd_flag   = 1'b0;
    endtask

    task automatic take_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MOTIF_LENGTH: len_reg     = data[LEN_W-1:0];
            CFG_THRESHOLD:    thresh_reg  = data[MIN_W-1:0];
            CFG_CODE_ROW0:    code_reg[0] = data[CODE_W-1:0];
            CFG_CODE_ROW1:    code_reg[1] = data[CODE_W-1:0];
            CFG_CODE_ROW2:    code_reg[2] = data[CODE_W-1:0];
            CFG_CODE_ROW3:    code_reg[3] = data[CODE_W-1:0];
            default: ;
        endcase
    endtask

    // Applies a weight load, or scores the window after one base and queues a verdict on the final base.
    task automatic score_item(input t_in_item it);
        logic [2:0] row_code;
        int         n;
        int         score;
        t_verdict   v;
        if (it.op == OP_LOAD) begin
            weights[{it.column, it.row}] = it.weight_value;
        end else begin
            row_code = ROW_NONE;
            for (int r = NUM_ROWS - 1; r >= 0; r--) begin
                if (it.base == code_reg[r]) row_code = 3'(r);
            end
            if (row_code == ROW_NONE) odd_flag = 1'b1;
            for (int i = COLUMNS - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = row_code;
            if (seen_count != SEEN_MAX) seen_count++;
            n = window_span(len_reg);
            if (int'(seen_count) >= n) begin
                score = 0;
                for (int i = 0; i < n; i++) begin
                    if (history[n-1-i] != ROW_NONE)
                        score += int'(weights[i*NUM_ROWS + history[n-1-i][1:0]]);
                end
                if (score >= int'(thresh_reg)) hit_flag = 1'b1;
            end
            if (it.last) begin
                v.matched      = (int'(seen_count) >= n) && hit_flag;
                v.unknown_seen = (int'(seen_count) >= n) && odd_flag;
                expected_verdicts.push_back(v);
                restart_scan();
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_in_item item;
        t_verdict want;
        if (!i_rst_n) begin
            len_reg      = LEN_RESET;
            thresh_reg   = MIN_RESET;
            code_reg     = CODE_RESET;
            o_fail_count = 0;
            for (int i = 0; i < COLUMNS * NUM_ROWS; i++) weights[i] = '0;
            restart_scan();
            expected_verdicts.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready)
                take_register(i_cfg_mon.reg_index, i_cfg_mon.wr_data);
            if (i_in_mon.valid && i_in_mon.ready) begin
                item.op           = i_in_mon.op;
                item.column       = i_in_mon.column;
                item.row          = i_in_mon.row;
                item.weight_value = i_in_mon.weight_value;
                item.base         = i_in_mon.base;
                item.last         = i_in_mon.last;
                score_item(item);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result, expected nothing, actual matched %0b unknown_seen %0b",
                             $time, i_out_mon.matched, i_out_mon.unknown_seen);
                    o_fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (want.matched !== i_out_mon.matched) begin
                        $display("%0t: matched mismatch, expected %0b, actual %0b",
                                 $time, want.matched, i_out_mon.matched);
                        o_fail_count++;
                    end
                    if (want.unknown_seen !== i_out_mon.unknown_seen) begin
                        $display("%0t: unknown_seen mismatch, expected %0b, actual %0b",
                                 $time, want.unknown_seen, i_out_mon.unknown_seen);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

/* verif/tb_pwm_motif_window_scan.sv */
`timescale 1ns / 100ps

module tb_pwm_motif_window_scan;
    import pmws_pkg::*;

    // The drain pause outlasts the slowest sequence byte, a scan over all 32 columns.
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 440;
    localparam int PHASE_ITEMS  = 60;
    localparam int COLUMNS      = 32;

    logic i_clk;
    logic i_rst_n;

    pmws_in_if  in_ch ();
    pmws_out_if out_ch ();
    pmws_cfg_if cfg_ch ();

    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   sent   = 0;
    logic in_taken;
    logic cfg_taken;
    bit   calm;

    // Shadows of the programmed codes and window, used only to shape the stimulus.
    logic [NUM_ROWS-1:0][CODE_W-1:0] codes_now;
    int                              window_now;

    pwm_motif_window_scan u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pmws_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Transfers are registered at the rising edge, so the drivers, which act on the falling
    // edge, see a stable record of whether their item was taken.
    always @(posedge i_clk) begin
        in_taken  <= in_ch.valid && in_ch.ready;
        cfg_taken <= cfg_ch.valid && cfg_ch.ready;
        cycles    <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The result side stalls about 37 percent of the time, except during the calm stretch.
    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 37);
    end

    // Presents one input item, after an optional random gap, and returns at the falling edge
    // that follows its transfer. Valid is left high so that back-to-back items need no
    // second assignment in the same time step.
    task automatic send_item(input t_op op, input logic [COLUMN_W-1:0] col,
                             input logic [ROW_W-1:0] row,
                             input logic signed [IN_WEIGHT_W-1:0] w,
                             input logic [CODE_W-1:0] b, input logic lst);
        if (!calm && $urandom_range(99) < 37) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.column       <= col;
        in_ch.row          <= row;
        in_ch.weight_value <= w;
        in_ch.base         <= b;
        in_ch.last         <= lst;
        do @(negedge i_clk); while (!in_taken);
        sent++;
    endtask

    // Same pattern for the register channel; end_writes lowers valid after a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (!calm && $urandom_range(99) < 37) begin
            cfg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(negedge i_clk); while (!cfg_taken);
        if (idx == CFG_MOTIF_LENGTH) begin
            window_now = (data[LEN_W-1:0] == 0) ? 1 :
                         (data[LEN_W-1:0] > COLUMNS) ? COLUMNS : int'(data[LEN_W-1:0]);
        end
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
    endtask

    // Brings the block to rest: every verdict has arrived and the last byte has had time to
    // finish its window scan, so that a register write cannot land on work in flight.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes every register. Unused bits of the narrow registers carry random junk, and now
    // and then one of the two unused indices is written as well, which must change nothing.
    task automatic apply_setting(input logic [LEN_W-1:0] len,
                                 input logic signed [MIN_W-1:0] thr,
                                 input logic [NUM_ROWS-1:0][CODE_W-1:0] codes);
        write_reg(CFG_MOTIF_LENGTH, {18'($urandom), len});
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_CODE_ROW0, {16'($urandom), codes[0]});
        write_reg(CFG_CODE_ROW1, {16'($urandom), codes[1]});
        write_reg(CFG_CODE_ROW2, {16'($urandom), codes[2]});
        write_reg(CFG_CODE_ROW3, {16'($urandom), codes[3]});
        if ($urandom_range(3) == 0) write_reg(3'(6 + $urandom_range(1)), 24'($urandom));
        end_writes();
        codes_now = codes;
    endtask

    // Most bytes hit one of the programmed codes; the rest are arbitrary and mostly unknown.
    function automatic logic [CODE_W-1:0] pick_base();
        if ($urandom_range(99) < 85) return codes_now[$urandom_range(NUM_ROWS - 1)];
        return 8'($urandom_range(255));
    endfunction

    function automatic int pick_length();
        if ($urandom_range(99) < 8) return $urandom_range(60, 72);
        return $urandom_range(1, 2 * window_now + 3);
    endfunction

    // One whole sequence ending on a byte flagged last. Now and then a weight load slips in
    // between bytes, with a random last bit that the block has to ignore.
    task automatic send_sequence(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 5)
                send_item(OP_LOAD, 5'($urandom), 2'($urandom), 16'($urandom),
                          8'($urandom), 1'($urandom));
            send_item(OP_BASE, 5'($urandom), 2'($urandom), 16'($urandom),
                      pick_base(), k == n - 1);
        end
    endtask

    initial begin : stimulus
        logic [NUM_ROWS-1:0][CODE_W-1:0] codes;
        logic [LEN_W-1:0]                len;
        logic signed [MIN_W-1:0]         thr;
        int                              spread;
        int                              budget;
        int                              random_start;
        int                              phase;

        // Every input is known from time zero, and reset is held low before it is released.
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_LOAD;
        in_ch.column       = '0;
        in_ch.row          = '0;
        in_ch.weight_value = '0;
        in_ch.base         = '0;
        in_ch.last         = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = '0;
        cfg_ch.wr_data     = '0;
        out_ch.ready       = 1'b0;
        calm               = 1'b0;
        codes_now          = CODE_RESET;
        window_now         = int'(LEN_RESET);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The weight memory has no defined reset, so the whole matrix is loaded first and no
        // window can ever read an entry that was never written.
        for (int c = 0; c < COLUMNS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++)
                send_item(OP_LOAD, 5'(c), 2'(r), 16'($urandom), 8'($urandom), 1'($urandom));
        end

        // Directed part, under the reset settings. The weight extremes come first, one of
        // them with last raised, which a load must ignore.
        send_item(OP_LOAD, 5'd0, 2'd0, 16'sh8000, 8'h00, 1'b0);
        send_item(OP_LOAD, 5'd31, 2'd3, 16'sh7fff, 8'hff, 1'b1);
        send_item(OP_LOAD, 5'd7, 2'd2, 16'sh0000, 8'h00, 1'b1);

        // A sequence shorter than the window, holding an unknown byte: both fields are zero.
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd65, 1'b0);
        send_item(OP_BASE, 5'd31, 2'd3, 16'shffff, 8'hff, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd67, 1'b1);

        // A full window of eight bases with an unknown byte inside it.
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd65, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd67, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd71, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd84, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'h00, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd65, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd67, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd71, 1'b1);

        // A lone base flagged last.
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd84, 1'b1);

        // Two rows share a code: the lower row must win, and the old code of row one is now
        // unknown.
        settle();
        apply_setting(6'd4, 24'sd0, {8'd84, 8'd71, 8'd65, 8'd65});
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd65, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd65, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd67, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd71, 1'b1);

        // The window length changes in mid-sequence, once the block is at rest between bytes,
        // and the new length applies from the next byte onwards.
        settle();
        apply_setting(6'd2, -24'sd5000, CODE_RESET);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd65, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd84, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd71, 1'b0);
        settle();
        write_reg(CFG_MOTIF_LENGTH, 24'd5);
        end_writes();
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd67, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd65, 1'b0);
        send_item(OP_BASE, 5'd0, 2'd0, 16'sh0000, 8'd67, 1'b1);

        // Random part. Each phase brings the block to rest, applies a fresh setting and then
        // streams whole sequences. The early phases take the extremes of the window length
        // and of the threshold; phases four and five form the stretch without any idling.
        random_start = sent;
        phase        = 0;
        while (sent - random_start < RANDOM_ITEMS) begin
            settle();
            calm = (phase == 4 || phase == 5);
            if ($urandom_range(9) < 8) len = 6'($urandom_range(1, 10));
            else                       len = 6'($urandom_range(0, 63));
            case (phase)
                0: len = 6'd1;
                1: len = 6'd32;
                2: len = 6'd0;
                3: len = 6'd63;
                4: len = 6'd40;
                default: ;
            endcase
            spread = 16000 * ((len == 0) ? 1 : (len > COLUMNS) ? COLUMNS : int'(len)) + 20000;
            thr = 24'($urandom_range(0, 2 * spread) - spread);
            if (phase == 0) thr = 24'h800000;
            if (phase == 1) thr = 24'h7fffff;
            codes = 32'($urandom);
            if (phase == 3) codes = {4{codes[0]}};
            else if ($urandom_range(3) == 0) codes[$urandom_range(3)] = codes[$urandom_range(3)];
            if (phase == 0 || phase == 2 || (phase > 5 && $urandom_range(1) == 0))
                codes = CODE_RESET;
            apply_setting(len, thr, codes);
            budget = sent + PHASE_ITEMS;
            while (sent < budget) send_sequence(pick_length());
            phase++;
        end
        calm = 1'b0;

        // Wind down: every verdict in, then the longest scan time for any stray transfer.
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
